// ===== rtl/core/hsvrgb_pkg.sv =====
`timescale 1ns / 1ps
// Shared field widths, item types and pipeline layout of the HSV to ARGB converter.
package hsvrgb_pkg;

  localparam int HUE_W   = 24;
  localparam int LEVEL_W = 13;
  localparam int BYTE_W  = 8;

  localparam int FRONT_STAGES = 5;
  localparam int LANE_STAGES  = 4;
  localparam int PIPE_DEPTH   = FRONT_STAGES + LANE_STAGES;

  typedef struct packed {
    logic signed [HUE_W-1:0] hue_degrees;
    logic [LEVEL_W-1:0]      saturation_level;
    logic [LEVEL_W-1:0]      brightness_level;
    logic [BYTE_W-1:0]       alpha_in;
  } hsv_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] alpha_out;
    logic [BYTE_W-1:0] red_channel;
    logic [BYTE_W-1:0] green_channel;
    logic [BYTE_W-1:0] blue_channel;
  } argb_item_t;

endpackage

// ===== rtl/core/hsvrgb_front.sv =====
`timescale 1ns / 1ps
// Front stages: hue reduction, sector split, chroma and per-channel weights.
module hsvrgb_front
  import hsvrgb_pkg::*;
#(
  parameter int HUE_FRAC_BITS   = 6,
  parameter int LEVEL_FRAC_BITS = 12
) (
  input  logic                                    clk,
  input  logic [FRONT_STAGES-1:0]                 en,
  input  logic signed [HUE_W-1:0]                 hue_degrees,
  input  logic [LEVEL_W-1:0]                      saturation_level,
  input  logic [LEVEL_W-1:0]                      brightness_level,
  output logic [2*LEVEL_W-1:0]                    chroma,
  output logic [LEVEL_W+HUE_FRAC_BITS+6+LEVEL_FRAC_BITS-1:0] base,
  output logic [HUE_FRAC_BITS+6-1:0]              t_red,
  output logic [HUE_FRAC_BITS+6-1:0]              t_green,
  output logic [HUE_FRAC_BITS+6-1:0]              t_blue
);

  localparam int P_W       = HUE_FRAC_BITS + 6;
  localparam int PERIOD    = 60 << HUE_FRAC_BITS;
  localparam int FULL      = 360 << HUE_FRAC_BITS;
  localparam int HR_W      = $clog2(FULL);
  localparam int U_W       = HUE_W + 1;
  localparam int OFF_TURNS = (2 ** (HUE_W - 1) + FULL - 1) / FULL;
  localparam int OFFSET    = OFF_TURNS * FULL;
  localparam int RECIP     = (2 ** U_W) / FULL;
  localparam int Q_W       = $clog2(RECIP + 1);
  localparam int C_W       = 2 * LEVEL_W;
  localparam int VP_W      = LEVEL_W + P_W;
  localparam int B_W       = VP_W + LEVEL_FRAC_BITS;

  typedef enum logic [2:0] {
    SEC_RED_YEL,
    SEC_YEL_GRN,
    SEC_GRN_CYN,
    SEC_CYN_BLU,
    SEC_BLU_MAG,
    SEC_MAG_RED
  } sector_t;

  // stage 1
  logic [U_W-1:0]     u1;
  logic [C_W-1:0]     c1;
  logic [LEVEL_W-1:0] val1;
  // stage 2
  logic [U_W+Q_W-1:0] qprod;
  logic [Q_W-1:0]     q2;
  logic [U_W-1:0]     u2;
  logic [C_W-1:0]     c2;
  logic [VP_W-1:0]    vp2;
  // stage 3
  logic [Q_W+HR_W-1:0] qfull;
  logic [U_W-1:0]      diff;
  logic [HR_W:0]       rem3;
  logic [C_W-1:0]      c3;
  logic [B_W-1:0]      base3;
  // stage 4
  logic [HR_W-1:0]     hr4;
  logic [C_W-1:0]      c4;
  logic [B_W-1:0]      base4;
  // stage 5 inputs
  sector_t             sec;
  logic [HR_W-1:0]     sec_start;
  logic [P_W-1:0]      pos;
  logic [P_W-1:0]      tsec;
  logic [P_W-1:0]      t_red_next, t_green_next, t_blue_next;

  assign qprod = u1 * Q_W'(RECIP);
  assign qfull = q2 * HR_W'(FULL);
  assign diff  = u2 - U_W'(qfull);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      // lift the hue onto the positive side by a whole number of turns
      u1   <= {hue_degrees[HUE_W-1], hue_degrees} + U_W'(OFFSET);
      c1   <= saturation_level * brightness_level;
      val1 <= brightness_level;
    end
    if (en[1]) begin
      q2  <= qprod[U_W+Q_W-1:U_W];
      u2  <= u1;
      c2  <= c1;
      vp2 <= val1 * P_W'(PERIOD);
    end
    if (en[2]) begin
      rem3  <= diff[HR_W:0];
      c3    <= c2;
      base3 <= B_W'(vp2) << LEVEL_FRAC_BITS;
    end
    if (en[3]) begin
      // quotient estimate may be one low: fold the remainder once
      hr4   <= (rem3 >= (HR_W+1)'(FULL)) ? HR_W'(rem3 - (HR_W+1)'(FULL)) : HR_W'(rem3);
      c4    <= c3;
      base4 <= base3;
    end
    if (en[4]) begin
      t_red   <= t_red_next;
      t_green <= t_green_next;
      t_blue  <= t_blue_next;
      chroma  <= c4;
      base    <= base4;
    end
  end

  always_comb begin
    sec       = SEC_RED_YEL;
    sec_start = '0;
    if (hr4 >= HR_W'(PERIOD)) begin
      sec       = SEC_YEL_GRN;
      sec_start = HR_W'(PERIOD);
    end
    if (hr4 >= HR_W'(2 * PERIOD)) begin
      sec       = SEC_GRN_CYN;
      sec_start = HR_W'(2 * PERIOD);
    end
    if (hr4 >= HR_W'(3 * PERIOD)) begin
      sec       = SEC_CYN_BLU;
      sec_start = HR_W'(3 * PERIOD);
    end
    if (hr4 >= HR_W'(4 * PERIOD)) begin
      sec       = SEC_BLU_MAG;
      sec_start = HR_W'(4 * PERIOD);
    end
    if (hr4 >= HR_W'(5 * PERIOD)) begin
      sec       = SEC_MAG_RED;
      sec_start = HR_W'(5 * PERIOD);
    end
    pos  = P_W'(hr4 - sec_start);
    // weight is the shortfall from full chroma: 0 full, PERIOD none
    tsec = sec[0] ? pos : P_W'(PERIOD) - pos;
    case (sec)
      SEC_RED_YEL: begin
        t_red_next = '0; t_green_next = tsec; t_blue_next = P_W'(PERIOD);
      end
      SEC_YEL_GRN: begin
        t_red_next = tsec; t_green_next = '0; t_blue_next = P_W'(PERIOD);
      end
      SEC_GRN_CYN: begin
        t_red_next = P_W'(PERIOD); t_green_next = '0; t_blue_next = tsec;
      end
      SEC_CYN_BLU: begin
        t_red_next = P_W'(PERIOD); t_green_next = tsec; t_blue_next = '0;
      end
      SEC_BLU_MAG: begin
        t_red_next = tsec; t_green_next = P_W'(PERIOD); t_blue_next = '0;
      end
      SEC_MAG_RED: begin
        t_red_next = '0; t_green_next = P_W'(PERIOD); t_blue_next = tsec;
      end
      default: begin
        t_red_next = '0; t_green_next = tsec; t_blue_next = P_W'(PERIOD);
      end
    endcase
  end

endmodule

// ===== rtl/core/hsvrgb_lane.sv =====
`timescale 1ns / 1ps
// One color channel: level numerator, clamp, scale to 255 and round.
module hsvrgb_lane
  import hsvrgb_pkg::*;
#(
  parameter int HUE_FRAC_BITS   = 6,
  parameter int LEVEL_FRAC_BITS = 12
) (
  input  logic                                    clk,
  input  logic [LANE_STAGES-1:0]                  en,
  input  logic [2*LEVEL_W-1:0]                    chroma,
  input  logic [LEVEL_W+HUE_FRAC_BITS+6+LEVEL_FRAC_BITS-1:0] base,
  input  logic [HUE_FRAC_BITS+6-1:0]              t,
  output logic [BYTE_W-1:0]                       chan
);

  localparam int P_W   = HUE_FRAC_BITS + 6;
  localparam int C_W   = 2 * LEVEL_W;
  localparam int B_W   = LEVEL_W + P_W + LEVEL_FRAC_BITS;
  localparam int PR_W  = C_W + P_W;
  localparam int SHIFT = HUE_FRAC_BITS + 2 * LEVEL_FRAC_BITS;
  localparam int D_W   = SHIFT + 6;
  localparam int M1_W  = (B_W > PR_W) ? B_W : PR_W;
  localparam int N_W   = ((M1_W > D_W) ? M1_W : D_W) + 1;
  localparam int SC_W  = D_W + 9;
  localparam int Y_W   = 15;
  localparam int Z_W   = Y_W - 3;
  localparam int QP_W  = Z_W + 9;
  localparam logic [D_W-1:0] DEN = D_W'(60) << SHIFT;
  localparam logic [Y_W-1:0] HALF_STEP = Y_W'(60);
  localparam logic [8:0]     RECIP15 = 9'd273;
  localparam logic [3:0]     DIV15   = 4'd15;

  logic [PR_W-1:0]       prod6;
  logic [B_W-1:0]        base6;
  logic signed [N_W-1:0] num;
  logic [D_W-1:0]        ncl7;
  logic [SC_W-1:0]       sc;
  logic [Y_W-1:0]        y;
  logic [Z_W-1:0]        z;
  logic [QP_W-1:0]       qp;
  logic [BYTE_W-1:0]     q8;
  logic [Z_W-1:0]        z8;
  logic [Z_W-1:0]        rem9;

  assign num  = $signed(N_W'(base6)) - $signed(N_W'(prod6));
  // scale by 510: 512 times minus twice
  assign sc   = {ncl7, 9'b0} - SC_W'({ncl7, 1'b0});
  assign y    = Y_W'(sc[SHIFT+Y_W-1:SHIFT]) + HALF_STEP;
  assign z    = y[Y_W-1:3];
  assign qp   = z * RECIP15;
  assign rem9 = z8 - Z_W'(q8 * DIV15);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      prod6 <= chroma * t;
      base6 <= base;
    end
    if (en[1]) begin
      if (num < 0) begin
        ncl7 <= '0;
      end else if (num > $signed(N_W'(DEN))) begin
        ncl7 <= DEN;
      end else begin
        ncl7 <= D_W'(num);
      end
    end
    if (en[2]) begin
      q8 <= qp[QP_W-2:QP_W-9];
      z8 <= z;
    end
    if (en[3]) begin
      // reciprocal estimate is at most one low
      chan <= (rem9 >= Z_W'(DIV15)) ? q8 + BYTE_W'(1) : q8;
    end
  end

endmodule

// ===== rtl/core/hsv_to_rgb_converter_unit.sv =====
`timescale 1ns / 1ps
// Top level of the HSV to ARGB color converter.
//
// Takes one HSV item per cycle and returns one 8-bit ARGB color per item,
// in order. The hue is signed fixed point (HUE_FRAC_BITS fraction bits), any
// number of turns, negative hues wrapping forward; saturation and value are
// unsigned with 1.0 at 1 << LEVEL_FRAC_BITS and may exceed it, the channel
// then clamping to 0 or 255. Each channel is scaled by 255 and rounded half
// up; alpha is copied. The register pipeline holds five front stages (hue
// offset, reciprocal quotient, remainder, wrap fix, sector select) and four
// per-channel stages (chroma weight product, clamp, scale and divide by 120,
// correction). Throughput is one item per cycle while color_ready stays high.
// A stall holds each stage that cannot move; empty stages upstream still
// fill, so pixel_ready drops only once every stage holds an item.
module hsv_to_rgb_converter_unit
  import hsvrgb_pkg::*;
#(
  parameter int HUE_FRAC_BITS   = 6,
  parameter int LEVEL_FRAC_BITS = 12
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       pixel_valid,
  output logic       pixel_ready,
  input  hsv_item_t  pixel,
  output logic       color_valid,
  input  logic       color_ready,
  output argb_item_t color
);

  localparam int P_W = HUE_FRAC_BITS + 6;
  localparam int C_W = 2 * LEVEL_W;
  localparam int B_W = LEVEL_W + P_W + LEVEL_FRAC_BITS;

  // stage occupancy and per-stage load enables
  logic [PIPE_DEPTH:1] valid;
  logic [PIPE_DEPTH:1] en;
  logic [BYTE_W-1:0]   alpha_pipe [1:PIPE_DEPTH];

  logic [C_W-1:0]    chroma;
  logic [B_W-1:0]    base;
  logic [P_W-1:0]    t_red, t_green, t_blue;
  logic [BYTE_W-1:0] red, green, blue;

  // a stage loads when it is empty or its content moves on
  always_comb begin
    en[PIPE_DEPTH] = !valid[PIPE_DEPTH] || color_ready;
    for (int k = PIPE_DEPTH - 1; k >= 1; k--) begin
      en[k] = !valid[k] || en[k+1];
    end
  end

  assign pixel_ready = en[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (en[1]) begin
        valid[1] <= pixel_valid;
      end
      for (int k = 2; k <= PIPE_DEPTH; k++) begin
        if (en[k]) begin
          valid[k] <= valid[k-1];
        end
      end
    end
  end

  // alpha rides alongside the arithmetic, one register per stage
  always_ff @(posedge clk) begin
    if (en[1]) begin
      alpha_pipe[1] <= pixel.alpha_in;
    end
    for (int k = 2; k <= PIPE_DEPTH; k++) begin
      if (en[k]) begin
        alpha_pipe[k] <= alpha_pipe[k-1];
      end
    end
  end

  hsvrgb_front #(
    .HUE_FRAC_BITS   (HUE_FRAC_BITS),
    .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
  ) u_front (
    .clk              (clk),
    .en               (en[FRONT_STAGES:1]),
    .hue_degrees      (pixel.hue_degrees),
    .saturation_level (pixel.saturation_level),
    .brightness_level (pixel.brightness_level),
    .chroma           (chroma),
    .base             (base),
    .t_red            (t_red),
    .t_green          (t_green),
    .t_blue           (t_blue)
  );

  hsvrgb_lane #(
    .HUE_FRAC_BITS   (HUE_FRAC_BITS),
    .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
  ) u_lane_red (
    .clk    (clk),
    .en     (en[PIPE_DEPTH:FRONT_STAGES+1]),
    .chroma (chroma),
    .base   (base),
    .t      (t_red),
    .chan   (red)
  );

  hsvrgb_lane #(
    .HUE_FRAC_BITS   (HUE_FRAC_BITS),
    .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
  ) u_lane_green (
    .clk    (clk),
    .en     (en[PIPE_DEPTH:FRONT_STAGES+1]),
    .chroma (chroma),
    .base   (base),
    .t      (t_green),
    .chan   (green)
  );

  hsvrgb_lane #(
    .HUE_FRAC_BITS   (HUE_FRAC_BITS),
    .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
  ) u_lane_blue (
    .clk    (clk),
    .en     (en[PIPE_DEPTH:FRONT_STAGES+1]),
    .chroma (chroma),
    .base   (base),
    .t      (t_blue),
    .chan   (blue)
  );

  assign color_valid         = valid[PIPE_DEPTH];
  assign color.alpha_out     = alpha_pipe[PIPE_DEPTH];
  assign color.red_channel   = red;
  assign color.green_channel = green;
  assign color.blue_channel  = blue;

  // input stalls only when every stage is occupied
  a_full_when_stalled: assert property (@(posedge clk) disable iff (rst)
    !pixel_ready |-> &valid)
    else $error("input stalled with an empty stage");

  // an item taken with none leaving adds exactly one occupied stage
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (pixel_valid && pixel_ready && !(color_valid && color_ready))
      |=> $countones(valid) == $past($countones(valid)) + 1)
    else $error("accepted item lost or duplicated in pipeline");

  // an item leaving with none taken frees exactly one stage
  a_count_down: assert property (@(posedge clk) disable iff (rst)
    (!(pixel_valid && pixel_ready) && color_valid && color_ready)
      |=> $countones(valid) + 1 == $past($countones(valid)))
    else $error("delivered item not retired from pipeline");

endmodule
